// ===== design/itoa_pkg.sv =====
package itoa_pkg;

    localparam int MaxField   = 63;
    localparam int DigitSlots = 32;
    localparam int DecDigits  = 20;
    localparam int CntW       = 6;
    localparam int DigW       = 5;

    typedef enum logic [1:0] {
        CMD_SDEC = 2'd0,
        CMD_UDEC = 2'd1,
        CMD_HEXL = 2'd2,
        CMD_HEXU = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Phase of the character being emitted
    typedef enum logic [2:0] {
        PH_LPAD,
        PH_PFX,
        PH_ZERO,
        PH_DIG,
        PH_RPAD
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic emit_start;
        logic emit_step;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic conv_done;
        logic emit_last;
    } dp_stat_t;

    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChSpace = 8'h20;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10)
            c = ChZero + {4'd0, nib};
        else if (upper)
            c = 8'h41 + {4'd0, nib} - 8'd10;
        else
            c = 8'h61 + {4'd0, nib} - 8'd10;
        return c;
    endfunction

endpackage

// ===== design/itoa_ctrl.sv =====
module itoa_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_fire,
    input  logic                out_full,
    input  itoa_pkg::dp_stat_t  stat,
    output itoa_pkg::dp_cmd_t   cmd,
    output logic                busy
);
    import itoa_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire) state_next = ST_CONV;
            ST_CONV:
                if (stat.conv_done) state_next = ST_EMIT;
            ST_EMIT:
                if ((!out_full || out_fire) && stat.emit_last) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = in_fire;
            end
            ST_CONV:
            begin
                cmd.conv_step  = !stat.conv_done;
                cmd.emit_start = stat.conv_done;
            end
            ST_EMIT:
                cmd.emit_step = !out_full || out_fire;
            default:
                busy = 1'b1;
        endcase
    end

endmodule

// ===== design/itoa_dpath.sv =====
module itoa_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          command,
    input  logic [63:0]         operand,
    input  logic [1:0]          size_class,
    input  logic                left_justify,
    input  logic                zero_pad,
    input  logic                plus_flag,
    input  logic                space_flag,
    input  logic                alternate,
    input  logic [5:0]          field_width,
    input  logic [5:0]          min_digits,
    input  itoa_pkg::dp_cmd_t   cmd,
    output itoa_pkg::dp_stat_t  stat,
    input  logic                out_fire,
    output logic                out_full,
    output logic [7:0]          out_char,
    output logic                last_char
);
    import itoa_pkg::*;

    logic [63:0]     mag_reg;
    logic [1:0]      cmd_reg;
    logic            lj_reg, zp_reg;
    logic [5:0]      fw_reg, md_reg;
    logic [1:0]      np_reg;
    logic [7:0]      pfx0_reg, pfx1_reg;
    logic [3:0]      dig_reg [DigitSlots];
    logic [DigW:0]   nd_reg;
    logic [6:0]      bits_reg;
    logic [CntW:0]   pad_reg, zeros_reg, cnt_reg, total_reg;
    phase_t          ph_reg;
    logic [CntW:0]   run_reg;
    logic [7:0]      char_reg;
    logic            last_reg, full_reg;

    logic [63:0] val, smask, mag_abs, mag_load;
    logic [6:0]  bits_load;
    logic        neg;

    // Mask operand to size class, take the magnitude
    always_comb
    begin
        case (size_class)
            2'd0:    smask = 64'hFF;
            2'd1:    smask = 64'hFFFF;
            2'd2:    smask = 64'hFFFF_FFFF;
            default: smask = '1;
        endcase
        val = operand & smask;
        case (size_class)
            2'd0:    neg = val[7];
            2'd1:    neg = val[15];
            2'd2:    neg = val[31];
            default: neg = val[63];
        endcase
        neg = neg && (command == CMD_SDEC);
        mag_abs = neg ? ((~val + 64'd1) & smask) : val;
        // Decimal shifts the magnitude out from its top bit
        case (size_class)
            2'd0:    begin mag_load = {mag_abs[7:0], 56'd0};  bits_load = 7'd8;  end
            2'd1:    begin mag_load = {mag_abs[15:0], 48'd0}; bits_load = 7'd16; end
            2'd2:    begin mag_load = {mag_abs[31:0], 32'd0}; bits_load = 7'd32; end
            default: begin mag_load = mag_abs;                bits_load = 7'd64; end
        endcase
        if (command[1])
            mag_load = mag_abs;
    end

    // Decimal: shift-and-add-3 binary to BCD, one operand bit per cycle,
    // then the digit count is registered.
    // Hex: one nibble per cycle from the bottom.
    logic        is_dec;
    logic [3:0]  bcd_adj [DecDigits];
    logic [3:0]  bcd_sh  [DecDigits];
    logic [DigW:0] nd_dec;
    assign is_dec = !cmd_reg[1];

    always_comb
    begin
        for (int k = 0; k < DecDigits; k++)
            bcd_adj[k] = (dig_reg[k] >= 4'd5) ? dig_reg[k] + 4'd3 : dig_reg[k];
        bcd_sh[0] = {bcd_adj[0][2:0], mag_reg[63]};
        for (int k = 1; k < DecDigits; k++)
            bcd_sh[k] = {bcd_adj[k][2:0], bcd_adj[k-1][3]};
        // highest nonzero digit sets the count, zero prints one digit
        nd_dec = (DigW+1)'(1);
        for (int k = 1; k < DecDigits; k++)
            if (dig_reg[k] != 4'd0)
                nd_dec = (DigW+1)'(k + 1);
    end

    assign stat.conv_done = (nd_reg != '0) &&
                            (is_dec || (mag_reg == '0) ||
                             (nd_reg == (DigW+1)'(DigitSlots)));

    // Layout sums
    logic [CntW+1:0] body, zeros, len, pad, mdx, ndx, fwx;
    always_comb
    begin
        ndx   = (CntW+2)'(nd_reg);
        mdx   = (CntW+2)'(md_reg);
        fwx   = (CntW+2)'(fw_reg);
        body  = (CntW+2)'(np_reg) + ndx;
        zeros = (mdx > ndx) ? mdx - ndx : '0;
        if (zp_reg && !lj_reg && md_reg == '0 && fwx > body)
            zeros = fwx - body;
        if (body >= (CntW+2)'(MaxField))
            zeros = '0;
        else if (zeros > (CntW+2)'(MaxField) - body)
            zeros = (CntW+2)'(MaxField) - body;
        len = body + zeros;
        pad = (fwx > len) ? fwx - len : '0;
        if (len >= (CntW+2)'(MaxField))
            pad = '0;
        else if (pad > (CntW+2)'(MaxField) - len)
            pad = (CntW+2)'(MaxField) - len;
    end

    // Current character
    phase_t      ph;
    logic [CntW:0] run;
    logic [7:0]  ch;
    always_comb
    begin
        ph  = ph_reg;
        run = run_reg;
        // skip empty phases
        for (int k = 0; k < 5; k++)
        begin
            if (run == '0)
            begin
                case (ph)
                    PH_LPAD: begin ph = PH_PFX;  run = (CntW+1)'(np_reg); end
                    PH_PFX:  begin ph = PH_ZERO; run = zeros_reg; end
                    PH_ZERO: begin ph = PH_DIG;  run = (CntW+1)'(nd_reg); end
                    PH_DIG:  begin ph = PH_RPAD; run = lj_reg ? pad_reg : '0; end
                    default: begin ph = PH_RPAD; run = (CntW+1)'(1); end
                endcase
            end
        end
        case (ph)
            PH_PFX:  ch = (run == (CntW+1)'(np_reg)) ? pfx0_reg : pfx1_reg;
            PH_ZERO: ch = ChZero;
            PH_DIG:  ch = hex_char(dig_reg[DigW'(run - 1'b1)], cmd_reg == CMD_HEXU);
            default: ch = ChSpace;
        endcase
    end
    assign stat.emit_last = (cnt_reg + 1'b1 == total_reg);

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (cmd.emit_step)
            full_reg <= 1'b1;
        else if (out_fire)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            lj_reg  <= left_justify;
            zp_reg  <= zero_pad;
            fw_reg  <= field_width;
            md_reg  <= min_digits;
            nd_reg  <= '0;
            mag_reg <= mag_load;
            bits_reg <= bits_load;
            for (int k = 0; k < DecDigits; k++)
                dig_reg[k] <= 4'd0;
            pfx1_reg <= (command == CMD_HEXU) ? 8'h58 : 8'h78;
            if (neg)
            begin
                np_reg <= 2'd1; pfx0_reg <= ChMinus;
            end
            else if (command == CMD_SDEC && plus_flag)
            begin
                np_reg <= 2'd1; pfx0_reg <= ChPlus;
            end
            else if (command == CMD_SDEC && space_flag)
            begin
                np_reg <= 2'd1; pfx0_reg <= ChSpace;
            end
            else if (command[1] && alternate && val != '0)
            begin
                np_reg <= 2'd2; pfx0_reg <= ChZero;
            end
            else
            begin
                np_reg <= 2'd0; pfx0_reg <= ChZero;
            end
        end
        if (cmd.conv_step)
        begin
            if (!is_dec)
            begin
                dig_reg[DigW'(nd_reg)] <= mag_reg[3:0];
                mag_reg <= {4'd0, mag_reg[63:4]};
                nd_reg  <= nd_reg + 1'b1;
            end
            else if (bits_reg != '0)
            begin
                for (int k = 0; k < DecDigits; k++)
                    dig_reg[k] <= bcd_sh[k];
                mag_reg  <= {mag_reg[62:0], 1'b0};
                bits_reg <= bits_reg - 1'b1;
            end
            else
                nd_reg <= nd_dec;
        end
        if (cmd.emit_start)
        begin
            zeros_reg <= zeros[CntW:0];
            pad_reg   <= pad[CntW:0];
            ph_reg    <= PH_LPAD;
            run_reg   <= lj_reg ? '0 : pad[CntW:0];
            cnt_reg   <= '0;
            total_reg <= (CntW+1)'(((len + pad) > (CntW+2)'(MaxField)) ?
                         (CntW+2)'(MaxField) : len + pad);
        end
        if (cmd.emit_step)
        begin
            ph_reg   <= ph;
            run_reg  <= run - 1'b1;
            cnt_reg  <= cnt_reg + 1'b1;
            char_reg <= ch;
            last_reg <= stat.emit_last;
        end
    end

    assign out_full  = full_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

endmodule

// ===== design/integer_to_ascii_formatter_core.sv =====
// Integer to ASCII formatter.
// s_axis carries one integer with its conversion and flags; m_axis returns
// the formatted field, one character per transaction, tlast on the last.
// One item at a time: s_axis_tready is high only while the block is idle.
// Hex conversion takes one nibble at a time from the bottom (1 to 16
// digits). Decimal conversion shifts the operand through a BCD register
// one bit per cycle, 8, 16, 32 or 64 bits by size class, then registers
// the digit count. The layout is then registered, and the field is emitted
// one character per cycle from the output register while the receiver
// accepts them (at most 63 characters). When the receiver stalls, the
// output register holds its character and emission pauses. Reset clears
// the controller and the output valid flag.
module integer_to_ascii_formatter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] command, [65:2] operand, [67:66] size_class, [68] left_justify,
    // [69] zero_pad, [70] plus_flag, [71] space_flag, [72] alternate,
    // [78:73] field_width, [84:79] min_digits, [87:85] zero
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_char
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    import itoa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     busy, out_full, in_fire, out_fire;

    assign s_axis_tready = !busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = out_full;

    itoa_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .out_full(out_full), .stat(stat), .cmd(cmd), .busy(busy)
    );

    itoa_dpath u_dpath
    (
        .clk(clk), .rst_n(rst_n),
        .command(s_axis_tdata[1:0]), .operand(s_axis_tdata[65:2]),
        .size_class(s_axis_tdata[67:66]), .left_justify(s_axis_tdata[68]),
        .zero_pad(s_axis_tdata[69]), .plus_flag(s_axis_tdata[70]),
        .space_flag(s_axis_tdata[71]), .alternate(s_axis_tdata[72]),
        .field_width(s_axis_tdata[78:73]), .min_digits(s_axis_tdata[84:79]),
        .cmd(cmd), .stat(stat), .out_fire(out_fire), .out_full(out_full),
        .out_char(m_axis_tdata), .last_char(m_axis_tlast)
    );

endmodule
